// ===== src/slope_rate_limiter_defines.svh =====
// ----------------------------------------------------------------------------
// slope_rate_limiter_defines
// assertion macros shared by the rate limiter checker
// ----------------------------------------------------------------------------
`ifndef SLOPE_RATE_LIMITER_DEFINES_SVH
`define SLOPE_RATE_LIMITER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SLR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slope_rate_limiter: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define SLR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("slope_rate_limiter: next-cycle check failed");

`endif

// ===== src/slr_pkg.sv =====
// ----------------------------------------------------------------------------
// slr_pkg
// shared types and constants of the slope rate limiter
// ----------------------------------------------------------------------------
package slr_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 32;
    localparam int STEP_WIDTH          = 31;
    localparam int CFG_INDEX_WIDTH     = 2;
    localparam int CFG_DATA_WIDTH      = STEP_WIDTH;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_INCREASE_STEP = 2'd0,
        CFG_DECREASE_STEP = 2'd1,
        CFG_REAL_FIRST    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [STEP_WIDTH-1:0] increase_step;
        logic [STEP_WIDTH-1:0] decrease_step;
        logic                  real_first;
    } slr_cfg_t;

endpackage

// ===== src/slr_stream_if.sv =====
// ----------------------------------------------------------------------------
// slr_stream_if
// valid/ready channels carrying the limiter's input and result transactions
// ----------------------------------------------------------------------------
interface slr_in_if #(
    parameter int VALUE_WIDTH = slr_pkg::VALUE_WIDTH_DEFAULT
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] target_value;
    logic signed [VALUE_WIDTH-1:0] measured_value;

    modport source (output valid, output target_value, output measured_value, input ready);
    modport sink   (input valid, input target_value, input measured_value, output ready);
endinterface

interface slr_out_if #(
    parameter int VALUE_WIDTH = slr_pkg::VALUE_WIDTH_DEFAULT
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] ramp_out;

    modport source (output valid, output ramp_out, input ready);
    modport sink   (input valid, input ramp_out, output ready);
endinterface

// ===== src/slr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// slr_cfg_regs
// configuration registers written through the plain write port
// ----------------------------------------------------------------------------
module slr_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [slr_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [slr_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    output slr_pkg::slr_cfg_t                    cfg
);
    import slr_pkg::*;

    slr_cfg_t cfg_reg;
    slr_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_INCREASE_STEP: cfg_next.increase_step = cfg_data;
                CFG_DECREASE_STEP: cfg_next.decrease_step = cfg_data;
                CFG_REAL_FIRST:    cfg_next.real_first    = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/slr_step_logic.sv =====
// ----------------------------------------------------------------------------
// slr_step_logic
// one limiter update: optional jump to measured value, then a bounded step
// ----------------------------------------------------------------------------
module slr_step_logic #(
    parameter int VALUE_WIDTH = slr_pkg::VALUE_WIDTH_DEFAULT
) (
    input  slr_pkg::slr_cfg_t              cfg,
    input  logic signed [VALUE_WIDTH-1:0]  planned,
    input  logic signed [VALUE_WIDTH-1:0]  target,
    input  logic signed [VALUE_WIDTH-1:0]  measured,
    output logic signed [VALUE_WIDTH-1:0]  result
);
    import slr_pkg::*;

    // wide enough for value plus step without overflow
    localparam int SW = ((VALUE_WIDTH > STEP_WIDTH) ? VALUE_WIDTH : STEP_WIDTH) + 2;

    logic signed [VALUE_WIDTH-1:0] start_val;
    logic                          jump;
    logic                          p_pos;
    logic                          p_neg;
    logic                          t_gt;
    logic                          t_lt;
    logic                          away;
    logic [STEP_WIDTH-1:0]         lim;
    logic signed [VALUE_WIDTH:0]   diff;
    logic [VALUE_WIDTH:0]          gap_mag;
    logic                          beyond;
    logic signed [SW-1:0]          start_x;
    logic signed [SW-1:0]          lim_x;
    logic signed [SW-1:0]          sum_x;
    logic signed [SW-1:0]          dif_x;
    logic signed [SW-1:0]          vmax_x;
    logic signed [SW-1:0]          vmin_x;
    logic signed [VALUE_WIDTH-1:0] stepped;

    always_comb
    begin
        jump = cfg.real_first &&
               (((target >= measured) && (measured >= planned)) ||
                ((target <= measured) && (measured <= planned)));
        start_val = jump ? measured : planned;

        p_neg = planned[VALUE_WIDTH-1];
        p_pos = !p_neg && (planned != '0);
        t_gt  = target > planned;
        t_lt  = target < planned;

        // from zero the increase step applies both ways
        away = (p_pos && t_gt) || (p_neg && t_lt) || (!p_pos && !p_neg);
        lim  = away ? cfg.increase_step : cfg.decrease_step;

        diff    = {planned[VALUE_WIDTH-1], planned} - {target[VALUE_WIDTH-1], target};
        gap_mag = diff[VALUE_WIDTH] ? $unsigned(-diff) : $unsigned(diff);
        beyond  = {{(SW-VALUE_WIDTH-1){1'b0}}, gap_mag} > {{(SW-STEP_WIDTH){1'b0}}, lim};

        start_x = {{(SW-VALUE_WIDTH){start_val[VALUE_WIDTH-1]}}, start_val};
        lim_x   = $signed({{(SW-STEP_WIDTH){1'b0}}, lim});
        vmax_x  = $signed({{(SW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}});
        vmin_x  = $signed({{(SW-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}});
        sum_x   = start_x + lim_x;
        dif_x   = start_x - lim_x;

        if (t_gt)
        begin
            stepped = (sum_x > vmax_x) ? vmax_x[VALUE_WIDTH-1:0] : sum_x[VALUE_WIDTH-1:0];
        end
        else
        begin
            stepped = (dif_x < vmin_x) ? vmin_x[VALUE_WIDTH-1:0] : dif_x[VALUE_WIDTH-1:0];
        end

        if (!t_gt && !t_lt)
        begin
            result = start_val;
        end
        else if (beyond)
        begin
            result = stepped;
        end
        else
        begin
            result = target;
        end
    end

endmodule

// ===== src/slope_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// slope_rate_limiter: asymmetric slew-rate limiter on signed fixed-point values
// pipeline: accepted inputs are registered in stage 1, results in the planned value register
// throughput: one transaction per cycle while the output is not stalled; the step logic is combinational
// reset: planned value and all configuration registers clear to zero
// ----------------------------------------------------------------------------
module slope_rate_limiter #(
    parameter int VALUE_WIDTH = slr_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    slr_in_if.sink                              in_ch,
    slr_out_if.source                           out_ch,
    input  logic                                cfg_we,
    input  logic [slr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [slr_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import slr_pkg::*;

    slr_cfg_t                      cfg;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic signed [VALUE_WIDTH-1:0] s1_target_reg;
    logic signed [VALUE_WIDTH-1:0] s1_measured_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [VALUE_WIDTH-1:0] planned_reg;
    logic signed [VALUE_WIDTH-1:0] planned_next;
    logic                          s1_advance;
    logic                          in_ready;
    logic                          in_take;

    slr_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    slr_step_logic #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_step_logic (
        .cfg      (cfg),
        .planned  (planned_reg),
        .target   (s1_target_reg),
        .measured (s1_measured_reg),
        .result   (planned_next)
    );

    // the plan advances together with the result register
    assign s1_advance     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ready       = !s1_valid_reg || s1_advance;
    assign in_take        = in_ch.valid && in_ready;
    assign s1_valid_next  = in_take || (s1_valid_reg && !s1_advance);
    assign out_valid_next = s1_advance || (out_valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            planned_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_advance)
            begin
                planned_reg <= planned_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_target_reg   <= in_ch.target_value;
            s1_measured_reg <= in_ch.measured_value;
        end
    end

    assign in_ch.ready     = in_ready;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.ramp_out = planned_reg;

endmodule

// ===== src/slr_checker.sv =====
// ----------------------------------------------------------------------------
// slr_checker
// port-level checks of the rate limiter, bound to the top level
// ----------------------------------------------------------------------------
`include "slope_rate_limiter_defines.svh"

module slr_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);

    // a stalled result stays offered
    `SLR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // input only backs up when the result register is full and stalled
    `SLR_ASSERT_SAME(a_ready_free, !in_ready, out_valid && !out_ready)

    // an accepted transaction finds the result side valid after the stage-1 and result registers (own or older result)
    `SLR_ASSERT_NEXT(a_in_to_out, in_valid && in_ready, ##1 out_valid)

endmodule

bind slope_rate_limiter slr_checker u_slr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
);

// ===== tb/sv/slr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_scoreboard
// watches the limiter's input, result and register write ports, keeps its own
// planned value and step settings, and compares each result transaction with
// the oldest predicted ramp value
// ----------------------------------------------------------------------------
module slr_scoreboard #(
    parameter int VALUE_WIDTH = slr_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    slr_in_if                                   in_ch,
    slr_out_if                                  out_ch,
    input  logic                                cfg_we,
    input  logic [slr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [slr_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  results_seen
);
    import slr_pkg::*;

    logic signed [VALUE_WIDTH-1:0] planned_q;
    logic [STEP_WIDTH-1:0]         increase_q;
    logic [STEP_WIDTH-1:0]         decrease_q;
    logic                          real_first_q;
    logic signed [VALUE_WIDTH-1:0] ramp_expected[$];
    int                            fails;
    int                            seen;

    // one control tick: optional jump to the measured value, then a limited
    // step toward the target decided from the planned value alone
    function automatic logic signed [VALUE_WIDTH-1:0] ramp_next(
        input logic signed [VALUE_WIDTH-1:0] plan,
        input logic signed [VALUE_WIDTH-1:0] tgt,
        input logic signed [VALUE_WIDTH-1:0] meas,
        input logic [STEP_WIDTH-1:0]         inc,
        input logic [STEP_WIDTH-1:0]         dec,
        input logic                          jump_en
    );
        longint p;
        longint t;
        longint r;
        longint o;
        longint lim;
        longint span;
        longint hi;
        longint lo;
        logic   up;
        logic   away;
        hi = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
        lo = -hi - 1;
        p = plan;
        t = tgt;
        r = meas;
        o = p;
        if (jump_en && ((t >= r && r >= p) || (t <= r && r <= p)))
        begin
            o = r;
        end
        if (t != p)
        begin
            up   = (t > p);
            // leaving zero counts as moving away from it in both directions
            away = (p == 0) || ((p > 0) == up);
            lim  = away ? {33'b0, inc} : {33'b0, dec};
            span = up ? t - p : p - t;
            if (span > lim)
            begin
                o = up ? o + lim : o - lim;
                if (o > hi)
                begin
                    o = hi;
                end
                if (o < lo)
                begin
                    o = lo;
                end
            end
            else
            begin
                o = t;
            end
        end
        return o[VALUE_WIDTH-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [VALUE_WIDTH-1:0] ramp;
        if (!rst_n)
        begin
            planned_q    = '0;
            increase_q   = '0;
            decrease_q   = '0;
            real_first_q = 1'b0;
            ramp_expected.delete();
            fails        = 0;
            seen         = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_INCREASE_STEP: increase_q   = cfg_data;
                    CFG_DECREASE_STEP: decrease_q   = cfg_data;
                    CFG_REAL_FIRST:    real_first_q = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                ramp = ramp_next(planned_q, in_ch.target_value, in_ch.measured_value,
                                 increase_q, decrease_q, real_first_q);
                planned_q = ramp;
                ramp_expected.push_back(ramp);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                seen++;
                if (ramp_expected.size() == 0)
                begin
                    $error("ramp_out: unexpected transaction, actual %0d", out_ch.ramp_out);
                    fails++;
                end
                else
                begin
                    ramp = ramp_expected.pop_front();
                    if (out_ch.ramp_out !== ramp)
                    begin
                        $error("ramp_out mismatch: expected %0d, actual %0d",
                               ramp, out_ch.ramp_out);
                        fails++;
                    end
                end
            end
        end
        fail_count   <= fails;
        pending      <= ramp_expected.size();
        results_seen <= seen;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives control ticks into the slope rate limiter under a series of step and
// real-first settings, with random gaps and stalls on both channels, and
// reports the verdict from the checker's failure count
// ----------------------------------------------------------------------------
module tb_top;

    import slr_pkg::*;

    localparam int VW           = VALUE_WIDTH_DEFAULT;
    localparam int RANDOM_TICKS = 900;
    localparam int PHASES       = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 600000;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam logic signed [VW-1:0]       VAL_MAX  = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0]       VAL_MIN  = {1'b1, {(VW-1){1'b0}}};
    localparam logic [STEP_WIDTH-1:0]      STEP_MAX = '1;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    int     fail_count;
    int     pending;
    int     results_seen;
    int     ticks_sent;
    int     settings_used;
    int     cycles;
    bit     idle_on;
    bit     hold_req;

    slr_in_if  #(.VALUE_WIDTH(VW)) in_ch ();
    slr_out_if #(.VALUE_WIDTH(VW)) out_ch ();

    slope_rate_limiter #(
        .VALUE_WIDTH(VW)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    slr_scoreboard #(
        .VALUE_WIDTH(VW)
    ) ramp_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .results_seen(results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL slope_rate_limiter");
        $finish;
    end

    function automatic int draw_gap();
        return idle_on ? int'($urandom_range(0, 14)) : 0;
    endfunction

    function automatic logic signed [VW-1:0] rand_value();
        int s;
        case ($urandom_range(0, 9))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2, 3: return $urandom;
            4: return VAL_MAX - $urandom_range(0, 1 << 18);
            5: return VAL_MIN + $urandom_range(0, 1 << 18);
            default:
            begin
                s = int'($urandom_range(0, 1 << 21)) - (1 << 20);
                return s;
            end
        endcase
    endfunction

    function automatic logic [STEP_WIDTH-1:0] rand_step();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return STEP_MAX;
            2: return STEP_WIDTH'($urandom_range(1, 255));
            3, 4: return STEP_WIDTH'($urandom_range(256, 1 << 20));
            5: return STEP_WIDTH'($urandom_range(1 << 20, 1 << 26));
            default: return STEP_WIDTH'($urandom);
        endcase
    endfunction

    // a point on the way from a to b, so real-first jumps actually happen
    function automatic logic signed [VW-1:0] between_value(
        input logic signed [VW-1:0] a,
        input logic signed [VW-1:0] b
    );
        longint la;
        longint lb;
        longint m;
        la = a;
        lb = b;
        m  = la + ((lb - la) * longint'($urandom_range(0, 16))) / 16;
        return m[VW-1:0];
    endfunction

    task automatic send_tick(input logic signed [VW-1:0] tgt, input logic signed [VW-1:0] meas);
        int gap_cycles;
        gap_cycles = draw_gap();
        if (gap_cycles > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap_cycles) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.target_value   <= tgt;
        in_ch.measured_value <= meas;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        ticks_sent++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // all three registers plus a write past the list, only while idle
    task automatic set_limits(
        input logic [STEP_WIDTH-1:0]     inc,
        input logic [STEP_WIDTH-1:0]     dec,
        input logic [CFG_DATA_WIDTH-1:0] jump_data
    );
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INCREASE_STEP;
        cfg_data  <= inc;
        @(posedge clk);
        cfg_index <= CFG_DECREASE_STEP;
        cfg_data  <= dec;
        @(posedge clk);
        cfg_index <= CFG_REAL_FIRST;
        cfg_data  <= jump_data;
        @(posedge clk);
        cfg_index <= CFG_UNUSED_INDEX;
        cfg_data  <= CFG_DATA_WIDTH'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    initial
    begin : receiver
        int stall;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                // long back-pressure so the block fills and stalls its input
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = draw_gap();
                if (stall > 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
            begin
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int                  ph;
        int                  n;
        int                  k;
        int                  run;
        logic signed [VW-1:0] tgt;
        logic signed [VW-1:0] prev_tgt;

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_INCREASE_STEP;
        cfg_data             = '0;
        in_ch.valid          = 1'b0;
        in_ch.target_value   = '0;
        in_ch.measured_value = '0;
        idle_on              = 1'b1;
        hold_req             = 1'b0;
        ticks_sent           = 0;
        settings_used        = 0;
        prev_tgt             = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero steps hold the output, equal target takes no step
        send_tick(32'sd100, 32'sd0);
        send_tick(32'sd0, 32'sd0);
        send_tick(-32'sd100, 32'sd5);

        // full-scale steps, still short of a full-range swing; real-first set through a wide write
        set_limits(STEP_MAX, STEP_MAX, '1);
        send_tick(VAL_MAX, VAL_MIN);
        send_tick(VAL_MIN, 32'sd0);
        send_tick(VAL_MIN, VAL_MIN);
        send_tick(32'sd0, 32'sd0);

        // jumps to the measured value, one of them pushed past the bottom of the range
        set_limits(31'h4000_0000, 31'h0001_0000, 31'd1);
        send_tick(VAL_MAX, VAL_MAX - 1);
        send_tick(VAL_MIN, VAL_MAX);
        send_tick(VAL_MIN, VAL_MIN + 1);
        send_tick(VAL_MIN, 32'sd7);
        send_tick(VAL_MAX, 32'sd0);

        // unit step away from zero, full step toward it, no jump
        set_limits(31'd1, STEP_MAX, '0);
        send_tick(-32'sd5, 32'sd100);
        send_tick(-32'sd1000, -32'sd3);
        send_tick(32'sd3, 32'sd3);

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: set_limits(STEP_MAX, STEP_MAX, '1);
                1: set_limits('0, '0, 31'h7FFF_FFFE);
                default: set_limits(rand_step(), rand_step(), CFG_DATA_WIDTH'($urandom));
            endcase
            idle_on = (ph == 2 || ph == 4) ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (ph == 4)
            begin
                hold_req = 1'b1;
            end
            n = 0;
            while (n < RANDOM_TICKS / PHASES)
            begin
                // hold one target for a while so the output ramps toward it
                tgt = rand_value();
                run = $urandom_range(1, 12);
                for (k = 0; k < run && n < RANDOM_TICKS / PHASES; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        send_tick(rand_value(), rand_value());
                    end
                    else if ($urandom_range(0, 2) == 0)
                    begin
                        send_tick(tgt, rand_value());
                    end
                    else
                    begin
                        send_tick(tgt, between_value(prev_tgt, tgt));
                    end
                    n++;
                end
                prev_tgt = tgt;
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        $display("covered %0d ticks over %0d register settings, real-first on and off,",
                 ticks_sent, settings_used);
        $display("zero, small and full-scale steps; %0d ramp results compared", results_seen);
        if (fail_count == 0)
        begin
            $display("PASS slope_rate_limiter");
        end
        else
        begin
            $display("FAIL slope_rate_limiter");
        end
        $finish;
    end

endmodule
